>>> rtl/core/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and codes of the LED step sequencer: item actions, register
// indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lss_pkg;

   // item action codes (req_tuser)
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FINAL_LEVEL  = 2'd0;
   localparam logic [1:0] CSR_REPEAT_COUNT = 2'd1;
   localparam logic [1:0] CSR_STEP_COUNT   = 2'd2;

   localparam int unsigned REQ_DATA_BITS = 32;
   localparam int unsigned RSP_DATA_BITS = 32;
   localparam int unsigned CSR_DATA_BITS = 16;

   localparam logic [14:0]        PASS_MAX       = 15'h7FFF;
   localparam logic signed [15:0] REPEAT_FOREVER = -16'sd1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic tbl_write;   // write the table entry of the item
      logic tick_count;  // count the running hold down by one
      logic start_clear; // clear pointer, passes and countdown
      logic stop_timer;  // countdown expired
      logic rd_issue;    // read the table entry of the next step
      logic rd_zero;     // read entry zero instead of the pointer
      logic run_step;    // apply the step read in the previous cycle
      logic load_rsp;    // load the result register
      logic rsp_update;  // result reports a new level
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] action;
      logic       timer_running;
      logic       hold_last;
      logic       rsp_free;
   } ctrl_stat_type;

endpackage

>>> rtl/core/lss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/lss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer controller: decodes accepted items and steps the datapath
// through the table read and step application.
// ----------------------------------------------------------------------------
module lss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lss_pkg::ctrl_stat_type stat,
   output lss_pkg::ctrl_cmd_type  cmd
);

   lss_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_tready = (state_ff == lss_pkg::ST_IDLE) && stat.rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (accept) begin
               if (stat.action == lss_pkg::ACT_START) begin
                  state_in = lss_pkg::ST_RUN;
               end else if (stat.action == lss_pkg::ACT_TICK && stat.timer_running &&
                            stat.hold_last) begin
                  state_in = lss_pkg::ST_RUN;
               end
            end
         end
         lss_pkg::ST_RUN: begin
            state_in = lss_pkg::ST_IDLE;
         end
         default: state_in = lss_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (accept) begin
               case (stat.action)
                  lss_pkg::ACT_TICK: begin
                     if (stat.timer_running && stat.hold_last) begin
                        cmd.stop_timer = 1'b1;
                        cmd.rd_issue   = 1'b1;
                     end else begin
                        cmd.tick_count = stat.timer_running;
                        cmd.load_rsp   = 1'b1;
                     end
                  end
                  lss_pkg::ACT_WRITE: begin
                     cmd.tbl_write = 1'b1;
                     cmd.load_rsp  = 1'b1;
                  end
                  lss_pkg::ACT_START: begin
                     cmd.start_clear = 1'b1;
                     cmd.rd_issue    = 1'b1;
                     cmd.rd_zero     = 1'b1;
                  end
                  default: begin
                     cmd.load_rsp = 1'b1;
                  end
               endcase
            end
         end
         lss_pkg::ST_RUN: begin
            cmd.run_step   = 1'b1;
            cmd.load_rsp   = 1'b1;
            cmd.rsp_update = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/core/lss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_datapath
// Sequencer datapath: configuration registers, step table, step pointer,
// pass counter, hold countdown and the result register.
// ----------------------------------------------------------------------------
module lss_datapath #(
   parameter int MAX_STEPS  = 128,
   parameter int LEVEL_BITS = 8,
   parameter int HOLD_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [lss_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [lss_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [1:0]                          req_tuser,
   input  lss_pkg::ctrl_cmd_type               cmd,
   output lss_pkg::ctrl_stat_type              stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lss_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int ADDR_BITS = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int PTR_BITS  = $clog2(MAX_STEPS + 1);
   localparam int CMP_BITS  = (PTR_BITS > 8) ? PTR_BITS : 8;
   // one bit above the index so the table depth itself fits
   localparam int IDX_BITS  = ((ADDR_BITS > 7) ? ADDR_BITS : 7) + 1;
   localparam int CUR_BITS  = (LEVEL_BITS > 8) ? LEVEL_BITS : 8;
   localparam int ENT_BITS  = LEVEL_BITS + HOLD_BITS;

   // configuration
   logic [7:0]         final_level_ff;
   logic signed [15:0] repeat_count_ff;
   logic [7:0]         step_count_ff;
   logic [CMP_BITS-1:0] step_count_sat;

   // sequencer state
   logic [PTR_BITS-1:0]  pointer_ff, pointer_in;
   logic [14:0]          passes_ff, passes_in;
   logic [HOLD_BITS-1:0] hold_ff, hold_in;
   logic                 running_ff, running_in;
   logic [CUR_BITS-1:0]  level_ff, level_in;

   // result register
   logic                             rsp_valid_ff;
   logic [lss_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   // item fields
   logic [6:0]  req_index;
   logic [7:0]  req_level;
   logic [15:0] req_hold;
   logic [IDX_BITS-1:0] idx_ext;
   logic                idx_ok;

   // table access
   logic [ADDR_BITS-1:0] rd_addr;
   logic [ENT_BITS-1:0]  wr_entry;
   logic [ENT_BITS-1:0]  rd_entry;

   // step application
   logic                in_range;
   logic [PTR_BITS-1:0] ptr_inc;
   logic [14:0]         pass_sat;

   assign req_index = req_tdata[6:0];
   assign req_level = req_tdata[14:7];
   assign req_hold  = req_tdata[30:15];

   assign idx_ext  = IDX_BITS'(req_index);
   assign idx_ok   = idx_ext < IDX_BITS'(MAX_STEPS);
   assign wr_entry = {HOLD_BITS'(req_hold), LEVEL_BITS'(req_level)};
   assign rd_addr  = cmd.rd_zero ? '0 : pointer_ff[ADDR_BITS-1:0];

   lss_ram #(
      .WIDTH (ENT_BITS),
      .DEPTH (MAX_STEPS)
   ) u_table (
      .clock (clock),
      .we    (cmd.tbl_write && idx_ok),
      .waddr (idx_ext[ADDR_BITS-1:0]),
      .wdata (wr_entry),
      .re    (cmd.rd_issue),
      .raddr (rd_addr),
      .rdata (rd_entry)
   );

   // step count saturates at the table depth
   assign step_count_sat = (CMP_BITS'(csr_wdata[7:0]) > CMP_BITS'(MAX_STEPS)) ?
                           CMP_BITS'(MAX_STEPS) : CMP_BITS'(csr_wdata[7:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         final_level_ff  <= '0;
         repeat_count_ff <= '0;
         step_count_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lss_pkg::CSR_FINAL_LEVEL:  final_level_ff  <= csr_wdata[7:0];
            lss_pkg::CSR_REPEAT_COUNT: repeat_count_ff <= $signed(csr_wdata[15:0]);
            lss_pkg::CSR_STEP_COUNT:   step_count_ff   <= step_count_sat[7:0];
            default: ;
         endcase
      end
   end

   assign in_range = CMP_BITS'(pointer_ff) < CMP_BITS'(step_count_ff);
   assign ptr_inc  = pointer_ff + PTR_BITS'(1);
   assign pass_sat = (passes_ff == lss_pkg::PASS_MAX) ? passes_ff : passes_ff + 15'd1;

   always_comb begin
      pointer_in = pointer_ff;
      passes_in  = passes_ff;
      hold_in    = hold_ff;
      running_in = running_ff;
      level_in   = level_ff;
      if (cmd.start_clear) begin
         pointer_in = '0;
         passes_in  = '0;
         hold_in    = '0;
         running_in = 1'b0;
      end
      if (cmd.stop_timer) begin
         hold_in    = '0;
         running_in = 1'b0;
      end
      if (cmd.tick_count) begin
         hold_in = hold_ff - HOLD_BITS'(1);
      end
      if (cmd.run_step) begin
         if (in_range) begin
            level_in   = CUR_BITS'(rd_entry[LEVEL_BITS-1:0]);
            hold_in    = rd_entry[ENT_BITS-1:LEVEL_BITS];
            running_in = (rd_entry[ENT_BITS-1:LEVEL_BITS] != '0);
            pointer_in = ptr_inc;
            if (CMP_BITS'(ptr_inc) >= CMP_BITS'(step_count_ff)) begin
               if (repeat_count_ff == lss_pkg::REPEAT_FOREVER) begin
                  pointer_in = '0;
               end else begin
                  passes_in = pass_sat;
                  // wrap while passes remain
                  if ($signed({1'b0, pass_sat}) < repeat_count_ff) begin
                     pointer_in = '0;
                  end
               end
            end
         end else begin
            level_in   = CUR_BITS'(final_level_ff);
            hold_in    = '0;
            running_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         passes_ff  <= '0;
         hold_ff    <= '0;
         running_ff <= 1'b0;
         level_ff   <= '0;
      end else begin
         pointer_ff <= pointer_in;
         passes_ff  <= passes_in;
         hold_ff    <= hold_in;
         running_ff <= running_in;
         level_ff   <= level_in;
      end
   end

   // result register: loaded from the state after the item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {7'd0, passes_in, running_in, cmd.rsp_update, level_in[7:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign stat.action        = req_tuser;
   assign stat.timer_running = running_ff;
   assign stat.hold_last     = (hold_ff == HOLD_BITS'(1));
   assign stat.rsp_free      = !rsp_valid_ff || rsp_tready;

endmodule

>>> rtl/core/led_step_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_step_sequencer_top
// LED step sequencer: plays a table of (level, hold ms) steps, counting
// hold times down on tick items and looping the pattern as configured.
// ----------------------------------------------------------------------------
//  channel  | ports              | carries
//  ---------+--------------------+-----------------------------------------
//  request  | req_t*             | tick, table write or start item
//  response | rsp_t*             | one result item per request item
//  config   | csr_we/index/wdata | final_level, repeat_count, step_count
//
//  Tick, table write and unused items load the result at once; a start item
//  or an expiring tick reads the table, then applies the registered entry.
//  A new item is taken only when the output register is empty or is read in
//  the same cycle; a result held by the receiver stalls the input.
//  Synchronous reset clears all control state; the step table is not cleared
//  and holds nothing defined until written.
// ----------------------------------------------------------------------------
module led_step_sequencer_top #(
   parameter int MAX_STEPS  = 128,
   parameter int LEVEL_BITS = 8,
   parameter int HOLD_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] step_index, [14:7] step_level, [30:15] step_hold_ms
   input  logic [31:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] level, [8] level_update, [9] busy_res, [24:10] pass_count
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   lss_pkg::ctrl_cmd_type  cmd;
   lss_pkg::ctrl_stat_type stat;

   lss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lss_datapath #(
      .MAX_STEPS  (MAX_STEPS),
      .LEVEL_BITS (LEVEL_BITS),
      .HOLD_BITS  (HOLD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/tb_led_step_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_step_sequencer_top
// Self-checking bench for the LED step sequencer. A short directed table
// covers reset state, the unused action, zero hold, one-shot, repeated and
// endless patterns. The step table is then filled and random tick, write,
// start and unused items run under a dozen register settings. Each result
// item is compared field by field to an in-bench model of the pattern player.
// ----------------------------------------------------------------------------
module tb_led_step_sequencer_top;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         TABLE_DEPTH = 128;
   localparam int         NUM_PHASES  = 12;
   localparam int         PHASE_ITEMS = 108;
   localparam int         MAX_REPORTS = 10;

   // packed so that it lines up with rsp_tdata[24:0]
   typedef struct packed {
      logic [14:0] pass_count;
      logic        busy;
      logic        level_update;
      logic [7:0]  level;
   } led_status_type;

   typedef struct {
      logic           is_reg;
      logic [1:0]     code;
      logic [6:0]     index;
      logic [7:0]     level;
      logic [15:0]    value;
      logic           pinned;
      led_status_type pin;
   } plan_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = lss_pkg::ACT_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = lss_pkg::CSR_FINAL_LEVEL;
   logic [15:0] csr_wdata  = '0;

   led_step_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // pattern player state as the bench sees it
   logic [7:0]  level_mem [TABLE_DEPTH];
   logic [15:0] hold_mem  [TABLE_DEPTH];
   int          step_ptr       = 0;
   int          passes         = 0;
   int          hold_left      = 0;
   logic        timer_on       = 1'b0;
   logic [7:0]  cur_level      = '0;
   logic [7:0]  final_level_reg = '0;
   int          repeat_reg     = 0;
   int          step_count_reg = 0;

   led_status_type status_q [$];
   plan_row_type   plan_q [$];

   int send_idle_pct = 23;
   int recv_idle_pct = 79;
   int fail_count    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int updates_seen  = 0;

   logic [15:0] final_plan  [NUM_PHASES] = '{16'h00, 16'hFF, 16'h5A, 16'h80, 16'h01, 16'h7F,
                                             16'hC3, 16'hFE, 16'h00, 16'hFF, 16'h3C, 16'hA5};
   logic [15:0] repeat_plan [NUM_PHASES] = '{16'hFFFF, 16'd2, 16'd0, 16'd3, 16'd1, 16'h7FFF,
                                             16'h8000, 16'hFFFF, 16'd2, 16'd4, 16'hFFFE, 16'd3};
   logic [15:0] count_plan  [NUM_PHASES] = '{16'd3, 16'd1, 16'd5, 16'd0, 16'd128, 16'd2,
                                             16'd4, 16'd200, 16'd255, 16'd7, 16'd3, 16'd6};

   initial begin
      forever #6 clock = ~clock;
   end

   // load the step at the pointer, or the final level once the pattern is done
   function automatic void advance_pattern();
      logic [7:0] lvl;
      int         hold;
      lvl  = final_level_reg;
      hold = 0;
      if (step_ptr < step_count_reg) begin
         lvl  = level_mem[step_ptr];
         hold = hold_mem[step_ptr];
         step_ptr++;
         if (step_ptr >= step_count_reg) begin
            if (repeat_reg == int'(lss_pkg::REPEAT_FOREVER)) begin
               step_ptr = 0;
            end else begin
               if (passes < int'(lss_pkg::PASS_MAX)) passes++;
               if (passes < repeat_reg) step_ptr = 0;
            end
         end
      end
      cur_level = lvl;
      hold_left = hold;
      timer_on  = (hold != 0);
   endfunction

   function automatic led_status_type predict_status(input logic [1:0] act,
                                                     input logic [6:0] idx,
                                                     input logic [7:0] lvl,
                                                     input logic [15:0] hold);
      led_status_type st;
      logic           upd;
      upd = 1'b0;
      case (act)
         lss_pkg::ACT_TICK: begin
            if (timer_on) begin
               hold_left = (hold_left - 1) & 16'hFFFF;
               if (hold_left == 0) begin
                  timer_on = 1'b0;
                  advance_pattern();
                  upd = 1'b1;
               end
            end
         end
         lss_pkg::ACT_WRITE: begin
            level_mem[idx] = lvl;
            hold_mem[idx]  = hold;
         end
         lss_pkg::ACT_START: begin
            timer_on  = 1'b0;
            hold_left = 0;
            passes    = 0;
            step_ptr  = 0;
            advance_pattern();
            upd = 1'b1;
         end
         default: ;
      endcase
      st.level        = cur_level;
      st.level_update = upd;
      st.busy         = timer_on;
      st.pass_count   = passes[14:0];
      return st;
   endfunction

   function automatic void apply_register(input logic [1:0] index, input logic [15:0] value);
      case (index)
         lss_pkg::CSR_FINAL_LEVEL:  final_level_reg = value[7:0];
         lss_pkg::CSR_REPEAT_COUNT: repeat_reg = int'($signed(value));
         lss_pkg::CSR_STEP_COUNT:   step_count_reg = (value[7:0] > TABLE_DEPTH) ? TABLE_DEPTH
                                                                                : int'(value[7:0]);
         default: ;
      endcase
   endfunction

   // mostly short holds so patterns advance, some zero and some very long ones
   function automatic logic [15:0] pick_hold();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return 16'd0;
      if (pick < 80) return 16'($urandom_range(3, 1));
      if (pick < 93) return 16'($urandom_range(20, 4));
      return 16'($urandom);
   endfunction

   function automatic void plan_item(input logic [1:0] act, input logic [6:0] idx,
                                     input logic [7:0] lvl, input logic [15:0] hold,
                                     input logic pinned = 1'b0,
                                     input led_status_type pin = '0);
      plan_row_type row;
      row.is_reg = 1'b0;
      row.code   = act;
      row.index  = idx;
      row.level  = lvl;
      row.value  = hold;
      row.pinned = pinned;
      row.pin    = pin;
      plan_q.push_back(row);
   endfunction

   function automatic void plan_register(input logic [1:0] index, input logic [15:0] value);
      plan_row_type row;
      row.is_reg = 1'b1;
      row.code   = index;
      row.index  = '0;
      row.level  = '0;
      row.value  = value;
      row.pinned = 1'b0;
      row.pin    = '0;
      plan_q.push_back(row);
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [6:0] idx, input logic [7:0] lvl,
                            input logic [15:0] hold, input logic pinned,
                            input led_status_type pin);
      led_status_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, hold, lvl, idx};
      do @(posedge clock); while (!req_tready);
      predicted = predict_status(act, idx, lvl, hold);
      status_q.push_back(pinned ? pin : predicted);
      items_sent++;
   endtask

   task automatic send_random_item();
      int          pick;
      int          top;
      logic [1:0]  act;
      logic [6:0]  idx;
      logic [7:0]  lvl;
      logic [15:0] hold;
      pick = $urandom_range(99);
      idx  = 7'($urandom);
      lvl  = 8'($urandom);
      hold = 16'($urandom);
      if (pick < 58) act = lss_pkg::ACT_TICK;
      else if (pick < 80) act = lss_pkg::ACT_WRITE;
      else if (pick < 92) act = lss_pkg::ACT_START;
      else act = ACT_UNUSED;
      if (act == lss_pkg::ACT_WRITE) begin
         // favor entries of the active pattern so edits show up in the output
         top = (step_count_reg > 0) ? step_count_reg - 1 : 0;
         if ($urandom_range(99) < 70) idx = 7'($urandom_range(top));
         hold = pick_hold();
      end
      send_item(act, idx, lvl, hold, 1'b0, '0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_register(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      led_status_type got;
      led_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[24:0];
         results_seen++;
         if (got.level_update) updates_seen++;
         if (status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("ERROR: unexpected result: level %h update %b busy %b passes %0d",
                        got.level, got.level_update, got.busy, got.pass_count);
         end else begin
            want = status_q.pop_front();
            if (got.level !== want.level || got.level_update !== want.level_update ||
                got.busy !== want.busy || got.pass_count !== want.pass_count) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"ERROR: result %0d: expected level %h update %b busy %b passes %0d,",
                            " got level %h update %b busy %b passes %0d"},
                           results_seen, want.level, want.level_update, want.busy,
                           want.pass_count, got.level, got.level_update, got.busy,
                           got.pass_count);
            end
         end
      end
   end

   initial begin
      plan_row_type row;
      int           p;
      int           n;

      // status literals read {passes, busy, update, level}
      plan_item(lss_pkg::ACT_TICK, 7'h7F, 8'hFF, 16'hFFFF, 1'b1, {15'd0, 1'b0, 1'b0, 8'h00});
      plan_item(lss_pkg::ACT_START, 7'h00, 8'h00, 16'h0000, 1'b1, {15'd0, 1'b0, 1'b1, 8'h00});
      plan_item(ACT_UNUSED, 7'h55, 8'hAA, 16'hAAAA, 1'b1, {15'd0, 1'b0, 1'b0, 8'h00});
      plan_register(lss_pkg::CSR_FINAL_LEVEL, 16'h00FF);
      plan_register(lss_pkg::CSR_STEP_COUNT, 16'd3);
      plan_register(lss_pkg::CSR_REPEAT_COUNT, 16'd2);
      plan_item(lss_pkg::ACT_WRITE, 7'd0, 8'h00, 16'd1);
      plan_item(lss_pkg::ACT_WRITE, 7'd1, 8'hFF, 16'd2);
      plan_item(lss_pkg::ACT_WRITE, 7'd2, 8'h5A, 16'd1);
      plan_item(lss_pkg::ACT_WRITE, 7'd127, 8'h81, 16'hFFFF);
      plan_item(lss_pkg::ACT_START, 7'h2A, 8'h3C, 16'h1234);
      // two passes, then the final level with the timer stopped
      for (n = 0; n < 7; n++) plan_item(lss_pkg::ACT_TICK, 7'(n), 8'(n), 16'(n));
      plan_item(lss_pkg::ACT_TICK, 7'h00, 8'h00, 16'h0000, 1'b1, {15'd2, 1'b0, 1'b1, 8'hFF});
      plan_item(lss_pkg::ACT_TICK, 7'h7F, 8'hFF, 16'hFFFF, 1'b1, {15'd2, 1'b0, 1'b0, 8'hFF});
      // endless one-step pattern, edited while it runs to a zero hold
      plan_register(lss_pkg::CSR_REPEAT_COUNT, 16'hFFFF);
      plan_register(lss_pkg::CSR_STEP_COUNT, 16'd1);
      plan_item(lss_pkg::ACT_START, 7'h00, 8'h00, 16'h0000);
      plan_item(lss_pkg::ACT_TICK, 7'h00, 8'h00, 16'h0000);
      plan_item(lss_pkg::ACT_WRITE, 7'd0, 8'h33, 16'd0);
      plan_item(lss_pkg::ACT_TICK, 7'h00, 8'h00, 16'h0000);
      plan_item(lss_pkg::ACT_TICK, 7'h00, 8'h00, 16'h0000);
      plan_register(lss_pkg::CSR_REPEAT_COUNT, 16'h8000);
      plan_register(lss_pkg::CSR_STEP_COUNT, 16'd2);
      plan_item(lss_pkg::ACT_START, 7'h7F, 8'hFF, 16'hFFFF);
      plan_item(lss_pkg::ACT_TICK, 7'h00, 8'h00, 16'h0000);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_q[i]) begin
         row = plan_q[i];
         if (row.is_reg) begin
            wait_idle();
            write_register(row.code, row.value);
         end else begin
            send_item(row.code, row.index, row.level, row.value, row.pinned, row.pin);
         end
      end

      // give every entry a value before any count can reach it
      for (n = 0; n < TABLE_DEPTH; n++)
         send_item(lss_pkg::ACT_WRITE, 7'(n), 8'($urandom), pick_hold(), 1'b0, '0);

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES / 3) begin
            send_idle_pct = 79;
            recv_idle_pct = 23;
         end else if (p == 2 * NUM_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_idle();
         write_register(lss_pkg::CSR_FINAL_LEVEL, final_plan[p]);
         write_register(lss_pkg::CSR_REPEAT_COUNT, repeat_plan[p]);
         write_register(lss_pkg::CSR_STEP_COUNT, count_plan[p]);
         send_item(lss_pkg::ACT_START, 7'($urandom), 8'($urandom), 16'($urandom), 1'b0, '0);
         repeat (PHASE_ITEMS) send_random_item();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Summary: %0d items sent, %0d results checked, %0d of them ran a step",
               items_sent, results_seen, updates_seen);
      $display("Summary: %0d register settings, endless, one-shot and full table, %0d mismatches",
               NUM_PHASES + 3, fail_count);
      if (fail_count == 0) begin
         $display("tb_led_step_sequencer_top OK");
      end else begin
         $display("tb_led_step_sequencer_top NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("ERROR: run did not finish in time, %0d results still pending", status_q.size());
      $display("tb_led_step_sequencer_top NOT OK");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/lss_pkg.sv
rtl/core/lss_ram.sv
rtl/core/lss_ctrl.sv
rtl/core/lss_datapath.sv
rtl/core/led_step_sequencer_top.sv
tb/tb_led_step_sequencer_top.sv
